// File: hw/rtl/fjrs_pkg.sv
// Shared types and constants of the feeder jam recovery sequencer.
package fjrs_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Feed timer loads, in ticks.
  localparam logic [7:0] SETTLE_TICKS  = 8'd200;
  localparam logic [7:0] RECOVER_TICKS = 8'd150;

  // Angle errors with a magnitude below this are treated as zero.
  localparam int unsigned DEADBAND = 50;

  // The free advance counter saturates here.
  localparam logic [3:0] ADV_MAX = 4'd15;

  // Reset values of the configuration registers.
  localparam logic [11:0] GATE_SPIN_RST   = 12'd180;
  localparam logic [14:0] GATE_SPEED_RST  = 15'd12000;
  localparam logic [14:0] STALL_THR_RST   = 15'd5000;
  localparam logic [7:0]  STALL_LIMIT_RST = 8'd3;
  localparam logic [19:0] FEED_STEP_RST   = 20'd32768;
  localparam logic [3:0]  EMPTY_LIMIT_RST = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE_SPIN   = 3'd0,
    CFG_GATE_SPEED  = 3'd1,
    CFG_STALL_THR   = 3'd2,
    CFG_STALL_LIMIT = 3'd3,
    CFG_FEED_STEP   = 3'd4,
    CFG_EMPTY_LIMIT = 3'd5,
    CFG_FAST_FIRE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_CHECK   = 3'd2,
    PH_BACKOFF = 3'd3,
    PH_REPUSH  = 3'd4,
    PH_VERIFY  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [11:0] gate_spin_ticks;
    logic [14:0] gate_speed;
    logic [14:0] stall_threshold;
    logic [7:0]  stall_retry_limit;
    logic [19:0] feed_step;
    logic [3:0]  empty_limit;
    logic        fast_fire_enable;
  } cfg_t;

  typedef struct packed {
    logic        fire_request;
    logic        override_key;
    logic        wheels_on;
    logic [31:0] feeder_angle;
    logic [15:0] feeder_drive;
  } in_item_t;

  typedef struct packed {
    logic [14:0] gate_speed_target;
    logic [31:0] feeder_angle_target;
    logic        ready_res;
    logic        empty_res;
    logic        shot_pulse;
    logic [2:0]  sequence_phase;
  } out_item_t;

endpackage

// File: hw/rtl/fjrs_in_if.sv
// Valid/ready channel carrying one tick item into the sequencer.
interface fjrs_in_if
  import fjrs_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/fjrs_out_if.sv
// Valid/ready channel carrying one result item out of the sequencer.
interface fjrs_out_if
  import fjrs_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/fjrs_core.sv
// Sequencer state and the single-tick next-state and result logic.
module fjrs_core
  import fjrs_pkg::*;
#(
  parameter int unsigned ANGLE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  localparam int unsigned AW = ANGLE_WIDTH;
  localparam int unsigned CW = (AW > 20) ? AW : 20;

  phase_e          phase_q, phase_d;
  logic            ready_q, ready_d;
  logic            empty_q, empty_d;
  logic [11:0]     gate_timer_q, gate_timer_d;
  logic [7:0]      feed_timer_q, feed_timer_d;
  logic [7:0]      stall_cnt_q, stall_cnt_d;
  logic [3:0]      adv_cnt_q, adv_cnt_d;
  logic [AW-1:0]   saved_err_q, saved_err_d;
  logic [AW-1:0]   target_q, target_d;
  logic            gate_active_q, gate_active_d;

  logic signed [31:0] angle_s;
  logic [AW-1:0]   meas;
  logic [15:0]     drv_mag;
  logic            stalled;
  logic [AW-1:0]   err_raw, emag_raw, err, emag;
  logic [AW-1:0]   step_w, half_w;
  logic [18:0]     half_n;
  logic            emag_gt_half;
  logic            shot;
  logic            gate_run;
  logic            gate_stop;
  logic            feed_expired;
  logic            free_pass;

  // Operand preparation.
  always_comb begin
    angle_s  = item_i.feeder_angle;
    meas     = AW'(angle_s);
    drv_mag  = item_i.feeder_drive[15] ? 16'(~item_i.feeder_drive + 16'd1)
                                       : item_i.feeder_drive;
    stalled  = drv_mag > {1'b0, cfg_i.stall_threshold};
    err_raw  = target_q - meas;
    emag_raw = err_raw[AW-1] ? AW'(~err_raw + 1'b1) : err_raw;
    if (emag_raw < AW'(DEADBAND)) begin
      err  = '0;
      emag = '0;
    end else begin
      err  = err_raw;
      emag = emag_raw;
    end
    step_w       = AW'(cfg_i.feed_step);
    half_n       = cfg_i.feed_step[19:1];
    half_w       = AW'(half_n);
    emag_gt_half = CW'(emag) > CW'(half_n);
  end

  always_comb begin
    phase_d       = phase_q;
    ready_d       = ready_q | item_i.override_key;
    empty_d       = empty_q;
    stall_cnt_d   = stall_cnt_q;
    adv_cnt_d     = adv_cnt_q;
    saved_err_d   = saved_err_q;
    target_d      = target_q;
    gate_active_d = 1'b0;
    gate_stop     = 1'b0;
    free_pass     = 1'b0;
    feed_expired  = (feed_timer_q == 8'd0);
    feed_timer_d  = feed_expired ? 8'd0 : feed_timer_q - 8'd1;

    // A request is taken only once the gate timer has run out.
    shot = item_i.fire_request && (gate_timer_q == 12'd0) && ready_d;
    if (shot) begin
      gate_timer_d = cfg_i.gate_spin_ticks;
      gate_run     = (cfg_i.gate_spin_ticks != 12'd0);
      ready_d      = 1'b0;
    end else begin
      gate_timer_d = (gate_timer_q == 12'd0) ? 12'd0 : gate_timer_q - 12'd1;
      gate_run     = (gate_timer_q > 12'd1);
    end

    // The end of a spin with friction on starts a feed step.
    if (item_i.wheels_on) begin
      if (gate_run) begin
        gate_active_d = 1'b1;
      end else if (gate_active_q) begin
        target_d     = target_q + step_w;
        feed_timer_d = SETTLE_TICKS;
        phase_d      = PH_SETTLE;
        gate_stop    = 1'b1;
        if (cfg_i.fast_fire_enable) begin
          ready_d = 1'b1;
        end
      end
    end

    if (!gate_stop && feed_expired) begin
      case (phase_q)
        PH_IDLE: begin
        end
        PH_SETTLE: begin
          phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          if (stalled) begin
            stall_cnt_d  = stall_cnt_q + 8'd1;
            phase_d      = PH_BACKOFF;
            feed_timer_d = RECOVER_TICKS;
          end else begin
            free_pass = 1'b1;
          end
        end
        PH_BACKOFF: begin
          phase_d      = PH_REPUSH;
          saved_err_d  = err;
          target_d     = target_q - err - half_w;
          feed_timer_d = RECOVER_TICKS;
        end
        PH_REPUSH: begin
          phase_d      = PH_VERIFY;
          target_d     = target_q + saved_err_q + half_w;
          feed_timer_d = RECOVER_TICKS;
        end
        PH_VERIFY: begin
          phase_d = PH_CHECK;
          if (stalled) begin
            if (stall_cnt_q > cfg_i.stall_retry_limit) begin
              stall_cnt_d = 8'd0;
              ready_d     = 1'b1;
              saved_err_d = '0;
              if (emag_gt_half) begin
                // Run ends with the feeder jammed but not empty.
                phase_d   = PH_IDLE;
                target_d  = meas;
                adv_cnt_d = 4'd0;
                empty_d   = 1'b0;
              end else begin
                free_pass = 1'b1;
              end
            end
          end else begin
            saved_err_d  = '0;
            target_d     = target_q + step_w;
            feed_timer_d = SETTLE_TICKS;
            if (adv_cnt_q < ADV_MAX) begin
              adv_cnt_d = adv_cnt_q + 4'd1;
            end
            empty_d = 1'b0;
          end
        end
        default: begin
          free_pass = 1'b1;
        end
      endcase
    end

    if (free_pass) begin
      if (adv_cnt_q >= cfg_i.empty_limit) begin
        phase_d   = PH_IDLE;
        target_d  = meas;
        ready_d   = 1'b1;
        adv_cnt_d = 4'd0;
        empty_d   = 1'b1;
      end else begin
        adv_cnt_d    = adv_cnt_q + 4'd1;
        phase_d      = PH_CHECK;
        target_d     = target_q + step_w;
        feed_timer_d = SETTLE_TICKS;
        empty_d      = 1'b0;
        if (item_i.override_key) begin
          ready_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.gate_speed_target   = gate_active_d ? cfg_i.gate_speed : 15'd0;
    res_o.feeder_angle_target = 32'(target_d);
    res_o.ready_res           = ready_d;
    res_o.empty_res           = empty_d;
    res_o.shot_pulse          = shot;
    res_o.sequence_phase      = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      ready_q       <= 1'b1;
      empty_q       <= 1'b0;
      gate_timer_q  <= 12'd0;
      feed_timer_q  <= 8'd0;
      stall_cnt_q   <= 8'd0;
      adv_cnt_q     <= 4'd0;
      saved_err_q   <= '0;
      target_q      <= '0;
      gate_active_q <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      ready_q       <= ready_d;
      empty_q       <= empty_d;
      gate_timer_q  <= gate_timer_d;
      feed_timer_q  <= feed_timer_d;
      stall_cnt_q   <= stall_cnt_d;
      adv_cnt_q     <= adv_cnt_d;
      saved_err_q   <= saved_err_d;
      target_q      <= target_d;
      gate_active_q <= gate_active_d;
    end
  end

endmodule

// File: hw/rtl/feeder_jam_recovery_sequencer.sv
// Top level of the feeder jam recovery sequencer.
//
// Each input item on in_if is one 1 ms control tick: fire request, override
// key, friction state, measured feeder angle and feeder drive. For every
// accepted item exactly one result item leaves on out_if, in order, with the
// gate wheel speed target, the feeder angle target, the ready and empty flags,
// the shot pulse and the current recovery phase.
// An accepted item is held in an input register; the whole tick update is
// one pass of combinational logic from there into the result register and
// the sequencer state. The result is offered from the result register, and
// one item per cycle is sustained while the receiver is ready.
// When the receiver stalls, the result register holds and the input register
// takes one more item; in_if.ready drops only when both are full.
// Reset clears both registers and loads the state and the configuration
// registers with their defaults. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must do so only while no item is in
// flight; the block does not enforce this. Unknown indexes are ignored.
module feeder_jam_recovery_sequencer
  import fjrs_pkg::*;
#(
  parameter int unsigned ANGLE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fjrs_in_if.sink               in_if,
  fjrs_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  out_item_t res;
  logic      advance;

  assign advance      = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || advance;
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_item_q;

  fjrs_core #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_item_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_spin_ticks   <= GATE_SPIN_RST;
      cfg_q.gate_speed        <= GATE_SPEED_RST;
      cfg_q.stall_threshold   <= STALL_THR_RST;
      cfg_q.stall_retry_limit <= STALL_LIMIT_RST;
      cfg_q.feed_step         <= FEED_STEP_RST;
      cfg_q.empty_limit       <= EMPTY_LIMIT_RST;
      cfg_q.fast_fire_enable  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GATE_SPIN:   cfg_q.gate_spin_ticks   <= cfg_data_i[11:0];
        CFG_GATE_SPEED:  cfg_q.gate_speed        <= cfg_data_i[14:0];
        CFG_STALL_THR:   cfg_q.stall_threshold   <= cfg_data_i[14:0];
        CFG_STALL_LIMIT: cfg_q.stall_retry_limit <= cfg_data_i[7:0];
        CFG_FEED_STEP:   cfg_q.feed_step         <= cfg_data_i[19:0];
        CFG_EMPTY_LIMIT: cfg_q.empty_limit       <= cfg_data_i[3:0];
        CFG_FAST_FIRE:   cfg_q.fast_fire_enable  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_item_q <= in_if.data;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

endmodule

// File: hw/rtl/fjrs_checker.sv
// Port-level checks of the sequencer's handshake and buffering, with its bind.
module fjrs_checker
  import fjrs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result item changed while stalled");

  // With the result register empty the input side can always take an item.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready although no result is waiting");

  // Only two items fit: after filling the input register behind a stalled
  // result, a new item needs the receiver to take one first.
  a_two_deep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && in_valid_i && in_ready_i
    |=> !in_ready_i || out_ready_i)
    else $error("more than two items buffered");

  // No result is offered while reset is asserted.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

endmodule

bind feeder_jam_recovery_sequencer fjrs_checker u_fjrs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_data_i (out_if.data)
);
